// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the port-level checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside of reset.
`define PDRV_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define PDRV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/pdrv_pkg.sv =====
// ----------------------------------------------------------------------------
// pdrv_pkg
// Constants and the shared divide-by-1023 helper of the position drive.
// ----------------------------------------------------------------------------
package pdrv_pkg;

  localparam logic [7:0]  TargetReset = 8'd60;
  localparam logic [7:0]  AngleSpan   = 8'd240;
  localparam logic [8:0]  PropScale   = 9'd500;
  localparam logic [3:0]  DerivScale  = 4'd10;
  localparam logic [11:0] DriveMax    = 12'd4095;
  // Smallest magnitude whose quotient by 1023 reaches the drive limit.
  localparam logic [28:0] DriveSatMag = 29'(4095 * 1023);

  localparam int NumW = 30;

  // floor(m / 1023) for m below 4096*1023. Uses 1023*q + r = 1024*q + r - q
  // twice, then one final correction.
  function automatic logic [12:0] div1023(input logic [22:0] m);
    logic [12:0] q0;
    logic [12:0] m1;
    logic [2:0]  q1;
    logic [10:0] r1;
    logic        c;
    q0 = m[22:10];
    m1 = {3'b000, m[9:0]} + q0;
    q1 = m1[12:10];
    r1 = {1'b0, m1[9:0]} + {8'd0, q1};
    c  = (r1 >= 11'd1023);
    return q0 + {10'd0, q1} + {12'd0, c};
  endfunction

endpackage

// ===== hdl/pdrv_drive_stage.sv =====
// ----------------------------------------------------------------------------
// pdrv_drive_stage
// Scales the PID sum by 1/1023 toward zero, clamps and splits into DAC levels.
// ----------------------------------------------------------------------------
module pdrv_drive_stage
  import pdrv_pkg::*;
(
  input  logic signed [NumW-1:0] num,
  output logic signed [12:0]     drive,
  output logic        [11:0]     forward_level,
  output logic        [11:0]     reverse_level
);

  logic              neg;
  logic [NumW-2:0]   mag;
  logic [NumW-1:0]   neg_num;
  logic [12:0]       quot;
  logic [11:0]       qmag;

  always_comb begin
    neg     = num[NumW-1];
    neg_num = -num;
    mag     = neg ? neg_num[NumW-2:0] : num[NumW-2:0];
    quot    = div1023(mag[22:0]);
    // Anything at or past the limit saturates before the quotient is needed.
    if (mag >= DriveSatMag) begin
      qmag = DriveMax;
    end else begin
      qmag = quot[11:0];
    end
    drive         = neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
    forward_level = (!neg) ? qmag : 12'd0;
    reverse_level = neg ? qmag : 12'd0;
  end

endmodule

// ===== hdl/pid_position_drive.sv =====
// ----------------------------------------------------------------------------
// pid_position_drive
// Discrete PID position controller producing a clamped drive per sample beat.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one control tick per beat: the angle sample
//   and the three gain samples. The output channel returns one beat per
//   input beat, in order: the signed drive, the forward and reverse DAC
//   levels, and the measured angle in degrees.
//   cfg_wr_en with cfg_wr_data sets the target angle; write it only while
//   the block is idle.
// Pipeline and throughput:
//   A beat passes through an input register, an error stage, a multiplier
//   stage, a sum stage and the output register. One beat is accepted every
//   cycle while the input is not stalled.
// Reset:
//   Synchronous, active low. The target returns to 60 degrees, the running
//   error sum and the last error clear, and all stages empty.
// Stall:
//   Each stage holds its beat while the one after it is full and stalled;
//   empty stages keep filling, so the input stalls only once every stage
//   holds a beat and out_stall is high.
// ----------------------------------------------------------------------------
module pid_position_drive
  import pdrv_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [9:0]         in_angle_sample,
  input  logic [9:0]         in_prop_gain_sample,
  input  logic [9:0]         in_integ_gain_sample,
  input  logic [9:0]         in_deriv_gain_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [12:0] out_drive,
  output logic [11:0]        out_forward_level,
  output logic [11:0]        out_reverse_level,
  output logic [7:0]         out_angle_degrees
);

  logic [7:0] target_r;

  // Controller state.
  logic signed [15:0] err_sum_r, err_sum_nxt;
  logic signed [8:0]  prev_err_r;

  // Input register.
  logic       v0_r;
  logic [9:0] samp0_r, kp0_r, ki0_r, kd0_r;

  // Error stage.
  logic               v1_r;
  logic [7:0]         ang1_r;
  logic signed [8:0]  err1_r;
  logic signed [9:0]  dif1_r;
  logic signed [15:0] sum1_r;
  logic [18:0]        kp500_1_r;
  logic [9:0]         ki1_r;
  logic [13:0]        kd10_1_r;

  // Product stage.
  logic               v2_r;
  logic [7:0]         ang2_r;
  logic signed [28:0] pterm2_r;
  logic signed [26:0] iterm2_r;
  logic signed [24:0] dterm2_r;

  // Sum stage.
  logic                  v3_r;
  logic [7:0]            ang3_r;
  logic signed [NumW-1:0] num3_r;

  logic out_valid_r;

  logic free_out, free3, free2, free1, free0;
  logic mv0, mv1, mv2, mv3, accept;

  logic [12:0]        ang_q;
  logic [17:0]        ang_prod;
  logic [7:0]         ang0;
  logic signed [8:0]  err0;
  logic signed [16:0] sum_ext;

  logic signed [12:0] drive_c;
  logic [11:0]        fwd_c, rev_c;

  // Handshake: a stage may take a beat when empty or when its beat moves on.
  always_comb begin
    free_out = !out_valid_r || !out_stall;
    mv3      = v3_r && free_out;
    free3    = !v3_r || mv3;
    mv2      = v2_r && free3;
    free2    = !v2_r || mv2;
    mv1      = v1_r && free2;
    free1    = !v1_r || mv1;
    mv0      = v0_r && free1;
    free0    = !v0_r || mv0;
    accept   = in_valid && free0;
  end

  assign in_stall = !free0;

  // Angle scaling and error.
  always_comb begin
    ang_prod = 18'(samp0_r) * 18'(AngleSpan);
    ang_q    = div1023({5'd0, ang_prod});
    ang0     = ang_q[7:0];
    err0     = $signed({1'b0, ang0}) - $signed({1'b0, target_r});
    sum_ext  = 17'(err_sum_r) + 17'(err0);
    if (sum_ext > 17'sd32767) begin
      err_sum_nxt = 16'sh7fff;
    end else if (sum_ext < -17'sd32768) begin
      err_sum_nxt = 16'sh8000;
    end else begin
      err_sum_nxt = sum_ext[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r    <= TargetReset;
      err_sum_r   <= '0;
      prev_err_r  <= '0;
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        target_r <= cfg_wr_data;
      end
      // The state advances exactly once per beat, as it leaves the input stage.
      if (mv0) begin
        err_sum_r  <= err_sum_nxt;
        prev_err_r <= err0;
      end
      if (free0) v0_r <= in_valid;
      if (free1) v1_r <= mv0;
      if (free2) v2_r <= mv1;
      if (free3) v3_r <= mv2;
      if (free_out) out_valid_r <= mv3;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      samp0_r <= in_angle_sample;
      kp0_r   <= in_prop_gain_sample;
      ki0_r   <= in_integ_gain_sample;
      kd0_r   <= in_deriv_gain_sample;
    end
    if (mv0) begin
      ang1_r    <= ang0;
      err1_r    <= err0;
      dif1_r    <= 10'(err0) - 10'(prev_err_r);
      sum1_r    <= err_sum_r;
      kp500_1_r <= 19'(kp0_r) * 19'(PropScale);
      ki1_r     <= ki0_r;
      kd10_1_r  <= 14'(kd0_r) * 14'(DerivScale);
    end
    if (mv1) begin
      ang2_r   <= ang1_r;
      pterm2_r <= $signed({1'b0, kp500_1_r}) * err1_r;
      iterm2_r <= $signed({1'b0, ki1_r}) * sum1_r;
      dterm2_r <= $signed({1'b0, kd10_1_r}) * dif1_r;
    end
    if (mv2) begin
      ang3_r <= ang2_r;
      num3_r <= NumW'(pterm2_r) + NumW'(iterm2_r) + NumW'(dterm2_r);
    end
    if (mv3) begin
      out_drive         <= drive_c;
      out_forward_level <= fwd_c;
      out_reverse_level <= rev_c;
      out_angle_degrees <= ang3_r;
    end
  end

  pdrv_drive_stage u_drive (
    .num           (num3_r),
    .drive         (drive_c),
    .forward_level (fwd_c),
    .reverse_level (rev_c)
  );

  assign out_valid = out_valid_r;

endmodule

// ===== hdl/pdrv_checker.sv =====
// ----------------------------------------------------------------------------
// pdrv_checker
// Port-level checks of the position drive, bound onto the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pdrv_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [12:0] out_drive,
  input logic [11:0]        out_forward_level,
  input logic [11:0]        out_reverse_level,
  input logic [7:0]         out_angle_degrees
);

  // Reset empties the pipeline, so no result beat follows a reset cycle.
  `PDRV_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result beat after reset")

  // The levels must agree with the sign and magnitude of the drive.
  `PDRV_ASSERT(a_fwd_match, clk, rst_n, out_valid && out_drive > 13'sd0 |-> out_forward_level == out_drive[11:0] && out_reverse_level == 12'd0, "forward level mismatch")

  `PDRV_ASSERT(a_rev_match, clk, rst_n, out_valid && out_drive <= 13'sd0 |-> out_forward_level == 12'd0 && out_reverse_level == 12'((-out_drive)), "reverse level mismatch")

  // The clamp never lets the most negative code through, and the angle stays in span.
  `PDRV_ASSERT(a_ranges, clk, rst_n, out_valid |-> out_drive != -13'sd4096 && out_angle_degrees <= 8'd240, "result out of range")

  `PDRV_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_drive) && $stable(out_angle_degrees), "stalled result changed")

endmodule

bind pid_position_drive pdrv_checker u_pdrv_checker (.*);

// ===== tb/sv/pid_position_drive_checker.sv =====
// ----------------------------------------------------------------------------
// pid_position_drive_checker
// Predicts the drive of every control tick and checks the result beats.
// ----------------------------------------------------------------------------
// Watches the target register port and both channels of the position drive.
// Every accepted tick runs through a cycle-free model of the controller that
// keeps its own target, error sum and last error. The result is queued. Every
// accepted result beat is compared field by field with the oldest queued
// result. The mismatch count and the number of outstanding results go back
// to the testbench top.
// ----------------------------------------------------------------------------
module pid_position_drive_checker
  import pdrv_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [9:0]         in_angle_sample,
  input  logic [9:0]         in_prop_gain_sample,
  input  logic [9:0]         in_integ_gain_sample,
  input  logic [9:0]         in_deriv_gain_sample,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [12:0] out_drive,
  input  logic [11:0]        out_forward_level,
  input  logic [11:0]        out_reverse_level,
  input  logic [7:0]         out_angle_degrees,
  output int                 fail_count,
  output int                 pending_beats
);

  localparam longint SumMax = 32767;
  localparam longint SumMin = -32768;

  typedef struct packed {
    logic signed [12:0] drive;
    logic [11:0]        forward_level;
    logic [11:0]        reverse_level;
    logic [7:0]         angle_degrees;
  } drive_result_t;

  drive_result_t      expected_drives[$];
  logic [7:0]         target_deg;
  logic signed [15:0] error_sum;
  logic signed [8:0]  last_error;

  // One control tick: works out the drive from the state left by the previous
  // tick, then moves the error sum and the last error on.
  function automatic drive_result_t step_controller(input logic [9:0] samp,
                                                    input logic [9:0] kp,
                                                    input logic [9:0] ki,
                                                    input logic [9:0] kd);
    longint        deg;
    longint        err;
    longint        acc;
    longint        level;
    longint        sum_next;
    drive_result_t r;
    deg = (longint'(samp) * longint'(AngleSpan)) / 1023;
    err = deg - longint'(target_deg);
    acc = longint'(kp) * longint'(PropScale) * err
        + longint'(ki) * longint'(error_sum)
        + longint'(kd) * longint'(DerivScale) * (err - longint'(last_error));
    // Signed division truncates toward zero, as the drive requires.
    level = acc / 1023;
    if (level > longint'(DriveMax)) level = longint'(DriveMax);
    if (level < -longint'(DriveMax)) level = -longint'(DriveMax);
    r.drive         = 13'(level);
    r.forward_level = (level > 0) ? 12'(level) : 12'd0;
    r.reverse_level = (level > 0) ? 12'd0 : 12'(-level);
    r.angle_degrees = 8'(deg);
    sum_next = longint'(error_sum) + err;
    if (sum_next > SumMax) sum_next = SumMax;
    if (sum_next < SumMin) sum_next = SumMin;
    error_sum  = 16'(sum_next);
    last_error = 9'(err);
    return r;
  endfunction

  task automatic report_field(input string field, input logic signed [31:0] want,
                              input logic signed [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    drive_result_t want;
    if (!rst_n) begin
      target_deg = TargetReset;
      error_sum  = '0;
      last_error = '0;
      expected_drives.delete();
      fail_count = 0;
    end else begin
      if (cfg_wr_en) target_deg = cfg_wr_data;
      if (out_valid && !out_stall) begin
        if (expected_drives.size() == 0) begin
          $display("%0t: result beat with no tick outstanding, drive %0d",
                   $time, out_drive);
          fail_count++;
        end else begin
          want = expected_drives.pop_front();
          report_field("drive", want.drive, out_drive);
          report_field("forward_level", want.forward_level, out_forward_level);
          report_field("reverse_level", want.reverse_level, out_reverse_level);
          report_field("angle_degrees", want.angle_degrees, out_angle_degrees);
        end
      end
      if (in_valid && !in_stall)
        expected_drives.push_back(step_controller(in_angle_sample, in_prop_gain_sample,
                                                  in_integ_gain_sample,
                                                  in_deriv_gain_sample));
    end
    pending_beats = expected_drives.size();
  end

endmodule

// ===== tb/sv/pid_position_drive_tb.sv =====
// ----------------------------------------------------------------------------
// pid_position_drive_tb
// Stimulus and verdict for the PID position drive.
// ----------------------------------------------------------------------------
// A directed set of ticks covers the sample and gain extremes, targets above
// the angle span and zero drive. Random phases follow, each with its own
// target; most of them push the angle away from the target so that the error
// sum runs into both of its limits. Both channels idle at random, and once the
// result side holds off long enough for the block to stall its input. The
// checker beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module pid_position_drive_tb;

  localparam int TicksPerPhase  = 250;
  localparam int LongHoldCycles = 64;
  localparam int IdleLimit      = 2000;
  localparam int DrainCycles    = 8;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [7:0]         cfg_wr_data;
  logic               in_valid;
  logic               in_stall;
  logic [9:0]         in_angle_sample;
  logic [9:0]         in_prop_gain_sample;
  logic [9:0]         in_integ_gain_sample;
  logic [9:0]         in_deriv_gain_sample;
  logic               out_valid;
  logic               out_stall;
  logic signed [12:0] out_drive;
  logic [11:0]        out_forward_level;
  logic [11:0]        out_reverse_level;
  logic [7:0]         out_angle_degrees;
  int                 check_failures;
  int                 pending_beats;

  bit tx_steady     = 1'b0;
  bit rx_steady     = 1'b0;
  bit long_hold_req = 1'b0;

  always #5 clk = ~clk;

  pid_position_drive u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_angle_sample      (in_angle_sample),
    .in_prop_gain_sample  (in_prop_gain_sample),
    .in_integ_gain_sample (in_integ_gain_sample),
    .in_deriv_gain_sample (in_deriv_gain_sample),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_drive            (out_drive),
    .out_forward_level    (out_forward_level),
    .out_reverse_level    (out_reverse_level),
    .out_angle_degrees    (out_angle_degrees)
  );

  pid_position_drive_checker u_check (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_angle_sample      (in_angle_sample),
    .in_prop_gain_sample  (in_prop_gain_sample),
    .in_integ_gain_sample (in_integ_gain_sample),
    .in_deriv_gain_sample (in_deriv_gain_sample),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_drive            (out_drive),
    .out_forward_level    (out_forward_level),
    .out_reverse_level    (out_reverse_level),
    .out_angle_degrees    (out_angle_degrees),
    .fail_count           (check_failures),
    .pending_beats        (pending_beats)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int idle_len();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  // Offers one tick, waits for the edge where the beat is taken, then now and then idles the input for a random gap.
  task automatic send_tick(input logic [9:0] samp, input logic [9:0] kp,
                           input logic [9:0] ki, input logic [9:0] kd);
    in_valid             <= 1'b1;
    in_angle_sample      <= samp;
    in_prop_gain_sample  <= kp;
    in_integ_gain_sample <= ki;
    in_deriv_gain_sample <= kd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!tx_steady && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat (idle_len()) @(posedge clk);
    end
  endtask

  // With lean set, the angle mostly sits at the far end from the target so
  // that the error keeps one sign and the error sum saturates.
  task automatic send_random_tick(input logic [7:0] tgt, input bit lean);
    logic [9:0] samp;
    logic [9:0] gain [3];
    if (lean && $urandom_range(0, 9) != 0)
      samp = (tgt < 8'd120) ? 10'($urandom_range(990, 1023)) : 10'($urandom_range(0, 30));
    else
      samp = 10'($urandom);
    foreach (gain[k]) begin
      case ($urandom_range(0, 3))
        0: gain[k] = 10'($urandom_range(0, 15));
        1: gain[k] = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
        default: gain[k] = 10'($urandom);
      endcase
    end
    send_tick(samp, gain[0], gain[1], gain[2]);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_beats != 0);
  endtask

  task automatic set_target(input logic [7:0] deg);
    hold_until_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= deg;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin : result_sink
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LongHoldCycles) @(posedge clk);
      end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat (idle_len()) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] phase_target [8];
    rst_n                <= 1'b0;
    cfg_wr_en            <= 1'b0;
    cfg_wr_data          <= '0;
    in_valid             <= 1'b0;
    in_angle_sample      <= '0;
    in_prop_gain_sample  <= '0;
    in_integ_gain_sample <= '0;
    in_deriv_gain_sample <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset target of 60 degrees: zero drive, sample extremes, each gain alone.
    send_tick(10'd0,    10'd0,    10'd0,    10'd0);
    send_tick(10'd1023, 10'd0,    10'd0,    10'd0);
    send_tick(10'd1023, 10'd1023, 10'd0,    10'd0);
    send_tick(10'd0,    10'd1023, 10'd0,    10'd0);
    send_tick(10'd0,    10'd0,    10'd1023, 10'd0);
    send_tick(10'd1023, 10'd0,    10'd0,    10'd1023);
    send_tick(10'd0,    10'd0,    10'd0,    10'd1023);
    send_tick(10'd255,  10'd1023, 10'd1023, 10'd1023);
    send_tick(10'd256,  10'd1023, 10'd0,    10'd0);
    send_tick(10'd1022, 10'd1,    10'd1,    10'd1);
    send_tick(10'd5,    10'd512,  10'd512,  10'd512);

    // A target beyond the angle span drives the error down to -255.
    set_target(8'd255);
    send_tick(10'd0,    10'd1023, 10'd1023, 10'd1023);
    send_tick(10'd1023, 10'd1023, 10'd0,    10'd0);
    send_tick(10'd0,    10'd0,    10'd0,    10'd1023);

    set_target(8'd0);
    send_tick(10'd0,    10'd1023, 10'd1023, 10'd1023);
    send_tick(10'd1023, 10'd1023, 10'd1023, 10'd1023);
    send_tick(10'd4,    10'd1023, 10'd0,    10'd0);
    send_tick(10'd5,    10'd0,    10'd0,    10'd1023);

    set_target(8'd240);
    send_tick(10'd1023, 10'd0,    10'd0,    10'd0);
    send_tick(10'd1023, 10'd0,    10'd1023, 10'd0);
    send_tick(10'd0,    10'd1,    10'd1,    10'd1);

    phase_target = '{8'd0, 8'd255, 8'd240, 8'd1, 8'($urandom_range(0, 255)),
                     8'd255, 8'd0, 8'($urandom_range(0, 255))};
    for (int ph = 0; ph < 8; ph++) begin
      set_target(phase_target[ph]);
      // The first phase opens with a long hold-off on the result side while
      // ticks keep coming, so the pipeline fills and the input stalls.
      if (ph == 0) long_hold_req = 1'b1;
      tx_steady = (ph == 0) || (ph == 3);
      rx_steady = (ph == 3);
      for (int n = 0; n < TicksPerPhase; n++) begin
        if (ph == 0 && n == 80) tx_steady = 1'b0;
        send_random_tick(phase_target[ph], ph < 6);
      end
    end

    hold_until_drained();
    repeat (DrainCycles) @(posedge clk);
    if (check_failures == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
